// File: hdl/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg: shared types and constants of the heading source selector
// Field widths, register reset values, register indexes, heading source codes
// and the structs that pass between the selector and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

  localparam int unsigned SPEED_W = 14;
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned QUO_W   = 14;
  localparam int unsigned PROD_W  = SPEED_W + QUO_W;
  localparam int unsigned CNT_W   = 4;

  localparam logic [SPEED_W-1:0]       PCT_FULL  = 14'd10000;
  localparam logic [HEAD_W:0]          FULL_TURN = 17'd36000;
  localparam logic signed [HEAD_W:0]   HALF_TURN = 17'sd18000;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 14'd300;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 14'd30;
  localparam logic [SPEED_W-1:0] ENTER_GPS_RST = 14'd60;
  localparam logic [SPEED_W-1:0] LEAVE_GPS_RST = 14'd40;
  localparam logic [HOLD_W-1:0]  BOAT_HOLD_RST = 16'd1000;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_SPEED = 3'd0,
    REG_MIN_SPEED = 3'd1,
    REG_ENTER_GPS = 3'd2,
    REG_LEAVE_GPS = 3'd3,
    REG_BOAT_HOLD = 3'd4
  } hss_reg_e;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_GPS   = 2'd1,
    SRC_BOAT  = 2'd2,
    SRC_MOTOR = 2'd3
  } hss_src_e;

  typedef struct packed {
    logic              trust;
    logic              usable;
    logic              course_ok;
    logic [HEAD_W-1:0] course;
    logic              motor_ok;
    logic [HEAD_W-1:0] motor;
    logic [HEAD_W-1:0] boat;
  } sel_in_t;

  typedef struct packed {
    logic [HEAD_W-1:0]        heading;
    logic                     ok;
    hss_src_e                 source;
    logic signed [HEAD_W-1:0] angle;
  } sel_out_t;

endpackage

`default_nettype wire

// File: hdl/hss_if.sv
// ----------------------------------------------------------------------------
// hss_if: channel interfaces of the heading source selector
// Navigation update channel, result channel and register write channel, each
// with valid/ready and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface hss_in_if;
  import hss_pkg::*;
  logic               valid;
  logic               ready;
  logic               speed_ok;
  logic [SPEED_W-1:0] ground_speed;
  logic               course_ok;
  logic [HEAD_W-1:0]  course_in;
  logic               motor_ok;
  logic [HEAD_W-1:0]  motor_heading;
  logic               boat_ok;
  logic [HEAD_W-1:0]  boat_heading;
  logic [TIME_W-1:0]  now_ms;

  modport source (output valid, speed_ok, ground_speed, course_ok, course_in, motor_ok,
                  motor_heading, boat_ok, boat_heading, now_ms, input ready);
  modport sink   (input valid, speed_ok, ground_speed, course_ok, course_in, motor_ok,
                  motor_heading, boat_ok, boat_heading, now_ms, output ready);
endinterface

interface hss_out_if;
  import hss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [SPEED_W-1:0]       speed_pct;
  logic [SPEED_W-1:0]       speed_out;
  logic [HEAD_W-1:0]        course_out;
  logic signed [HEAD_W-1:0] motor_angle;
  logic [HEAD_W-1:0]        heading_out;
  logic                     heading_ok;
  logic [1:0]               heading_source;
  logic                     boat_usable;

  modport source (output valid, speed_pct, speed_out, course_out, motor_angle, heading_out,
                  heading_ok, heading_source, boat_usable, input ready);
  modport sink   (input valid, speed_pct, speed_out, course_out, motor_angle, heading_out,
                  heading_ok, heading_source, boat_usable, output ready);
endinterface

interface hss_cfg_if;
  import hss_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/hss_div.sv
// ----------------------------------------------------------------------------
// hss_div: iterative restoring divider
// One compare/subtract unit produces one quotient bit per cycle. The upper
// half of the dividend must be below the divisor for the quotient to be exact.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_div import hss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [PROD_W-1:0]  dividend_i,
  input  wire logic [SPEED_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [QUO_W-1:0]        quot_o
);

  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;
  logic [SPEED_W-1:0] rem_q;
  logic [QUO_W-1:0]   low_q;
  logic [QUO_W-1:0]   quot_q;

  logic [SPEED_W:0]   trial;
  logic [SPEED_W:0]   diff;
  logic               fits;

  assign trial = {rem_q, low_q[QUO_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(QUO_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[PROD_W-1:QUO_W];
      low_q <= dividend_i[QUO_W-1:0];
    end else if (cnt_q != '0) begin
      rem_q  <= fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
      low_q  <= {low_q[QUO_W-2:0], 1'b0};
      quot_q <= {quot_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: hdl/hss_sel.sv
// ----------------------------------------------------------------------------
// hss_sel: heading selection and motor-to-boat angle
// Picks the heading by priority GPS course, boat, motor, none, and forms the
// motor minus boat angle wrapped into the half-open range of a half turn.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_sel import hss_pkg::*; (
  input  wire sel_in_t sel_i,
  output sel_out_t     sel_o
);

  logic [HEAD_W-1:0]        motor_red;
  logic [HEAD_W-1:0]        boat_red;
  logic signed [HEAD_W:0]   diff;
  logic signed [HEAD_W:0]   wrapped;

  // headings are at most 65535, so one subtract reduces them into a full turn
  assign motor_red = ({1'b0, sel_i.motor} >= FULL_TURN) ?
                     HEAD_W'({1'b0, sel_i.motor} - FULL_TURN) : sel_i.motor;
  assign boat_red  = ({1'b0, sel_i.boat} >= FULL_TURN) ?
                     HEAD_W'({1'b0, sel_i.boat} - FULL_TURN) : sel_i.boat;

  assign diff = $signed({1'b0, motor_red}) - $signed({1'b0, boat_red});

  always_comb begin
    if (diff > HALF_TURN) begin
      wrapped = diff - $signed(FULL_TURN);
    end else if (diff <= -HALF_TURN) begin
      wrapped = diff + $signed(FULL_TURN);
    end else begin
      wrapped = diff;
    end
  end

  always_comb begin
    sel_o.angle   = (sel_i.motor_ok && sel_i.usable) ? wrapped[HEAD_W-1:0] : '0;
    sel_o.heading = '0;
    sel_o.ok      = 1'b1;
    sel_o.source  = SRC_NONE;
    if (sel_i.trust && sel_i.course_ok) begin
      sel_o.heading = sel_i.course;
      sel_o.source  = SRC_GPS;
    end else if (sel_i.usable) begin
      sel_o.heading = sel_i.boat;
      sel_o.source  = SRC_BOAT;
    end else if (sel_i.motor_ok) begin
      sel_o.heading = sel_i.motor;
      sel_o.source  = SRC_MOTOR;
    end else begin
      sel_o.ok = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/heading_source_selector_top.sv
// ----------------------------------------------------------------------------
// heading_source_selector_top: heading source selector
// Per navigation update: GPS trust hysteresis, boat compass hold window,
// speed percentage through a serial divider, angle and heading selection.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   one navigation update per transfer (GPS speed and course, motor and
//          boat compass headings with valid flags, millisecond time).
//   out_o  one result per update: speed percentage, masked speed and course,
//          motor angle, selected heading with its source, boat usability.
//   cfg_i  register writes by index; always ready, take effect the next cycle.
//          Write only while no update is in flight.
// Timing: the sequencer steps through multiply, divider start, divide and output;
//   the divider retires one quotient bit per cycle (14 bits). The next update is
//   accepted only once the result has been loaded into the output register.
// in_i.ready is high only while the sequencer is idle. A finished result waits
//   in the output register; the sequencer may take the next update meanwhile
//   and holds its own result until the receiver takes the pending one.
// Reset: registers return to their reset values, GPS trust clears and the last
//   boat valid time is zero, so the boat compass counts as usable until the
//   time first reaches the hold window.
// ----------------------------------------------------------------------------
`default_nettype none

module heading_source_selector_top import hss_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hss_in_if.sink     in_i,
  hss_out_if.source  out_o,
  hss_cfg_if.sink    cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [SPEED_W-1:0] max_q, min_q, enter_q, leave_q;
  logic [HOLD_W-1:0]  hold_q;
  logic               trust_q;
  logic [TIME_W-1:0]  last_q;

  // latched update
  logic [SPEED_W-1:0] speed_q;
  logic [HEAD_W-1:0]  course_q;
  logic               course_ok_q;
  logic               motor_ok_q;
  logic [HEAD_W-1:0]  motor_q;
  logic [HEAD_W-1:0]  boat_q;
  logic               usable_q;
  logic               pct_zero_q;
  logic               pct_sat_q;
  logic [PROD_W-1:0]  prod_q;

  // output register
  logic                     out_valid_q;
  logic [SPEED_W-1:0]       out_pct_q;
  logic [SPEED_W-1:0]       out_speed_q;
  logic [HEAD_W-1:0]        out_course_q;
  logic signed [HEAD_W-1:0] out_angle_q;
  logic [HEAD_W-1:0]        out_heading_q;
  logic                     out_ok_q;
  hss_src_e                 out_source_q;
  logic                     out_usable_q;

  logic               in_xfer;
  logic               out_free;
  logic               out_load;
  logic [SPEED_W-1:0] speed_d;
  logic               trust_d;
  logic [TIME_W-1:0]  elapsed;
  logic               usable_d;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   div_quot;
  logic [SPEED_W-1:0] pct;
  sel_in_t            sel_in;
  sel_out_t           sel_out;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == ST_OUT) && out_free;
  assign cfg_i.ready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= MAX_SPEED_RST;
      min_q   <= MIN_SPEED_RST;
      enter_q <= ENTER_GPS_RST;
      leave_q <= LEAVE_GPS_RST;
      hold_q  <= BOAT_HOLD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MAX_SPEED: max_q   <= cfg_i.data[SPEED_W-1:0];
        REG_MIN_SPEED: min_q   <= cfg_i.data[SPEED_W-1:0];
        REG_ENTER_GPS: enter_q <= cfg_i.data[SPEED_W-1:0];
        REG_LEAVE_GPS: leave_q <= cfg_i.data[SPEED_W-1:0];
        REG_BOAT_HOLD: hold_q  <= cfg_i.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign speed_d  = in_i.speed_ok ? in_i.ground_speed : '0;
  assign elapsed  = in_i.now_ms - last_q;
  assign usable_d = in_i.boat_ok || (elapsed < TIME_W'(hold_q));

  always_comb begin
    trust_d = trust_q;
    if (!in_i.speed_ok) begin
      trust_d = 1'b0;
    end else if (!trust_q && (in_i.ground_speed >= enter_q)) begin
      trust_d = 1'b1;
    end else if (trust_q && (in_i.ground_speed <= leave_q)) begin
      trust_d = 1'b0;
    end
  end

  assign div_start = (state_q == ST_START);

  hss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (max_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign sel_in = '{
    trust:     trust_q,
    usable:    usable_q,
    course_ok: course_ok_q,
    course:    course_q,
    motor_ok:  motor_ok_q,
    motor:     motor_q,
    boat:      boat_q
  };

  hss_sel u_sel (
    .sel_i (sel_in),
    .sel_o (sel_out)
  );

  // dead band gives zero, speed at or above maximum saturates (covers zero max)
  assign pct = pct_zero_q ? '0 : (pct_sat_q ? PCT_FULL : div_quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      trust_q     <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            trust_q <= trust_d;
            if (in_i.boat_ok) begin
              last_q <= in_i.now_ms;
            end
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_START;
        end
        ST_START: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold the result until the output register is free
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      speed_q     <= speed_d;
      course_q    <= in_i.course_ok ? in_i.course_in : '0;
      course_ok_q <= in_i.course_ok;
      motor_ok_q  <= in_i.motor_ok;
      motor_q     <= in_i.motor_heading;
      boat_q      <= in_i.boat_heading;
      usable_q    <= usable_d;
      pct_zero_q  <= (speed_d < min_q) || (speed_d == '0);
      pct_sat_q   <= (speed_d >= max_q);
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(speed_q) * PROD_W'(PCT_FULL);
    end
    if (out_load) begin
      out_pct_q     <= pct;
      out_speed_q   <= speed_q;
      out_course_q  <= course_q;
      out_angle_q   <= sel_out.angle;
      out_heading_q <= sel_out.heading;
      out_ok_q      <= sel_out.ok;
      out_source_q  <= sel_out.source;
      out_usable_q  <= usable_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.speed_pct      = out_pct_q;
  assign out_o.speed_out      = out_speed_q;
  assign out_o.course_out     = out_course_q;
  assign out_o.motor_angle    = out_angle_q;
  assign out_o.heading_out    = out_heading_q;
  assign out_o.heading_ok     = out_ok_q;
  assign out_o.heading_source = out_source_q;
  assign out_o.boat_usable    = out_usable_q;

endmodule

`default_nettype wire

// File: hdl/hss_checker.sv
// ----------------------------------------------------------------------------
// hss_checker: port-level checks of the heading source selector
// Watches the update and result channels of the top level and is attached to
// it by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_checker import hss_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [SPEED_W-1:0] speed_pct_i,
  input wire logic [HEAD_W-1:0]  heading_out_i,
  input wire logic               heading_ok_i,
  input wire logic [1:0]         heading_source_i
);

  // a result stays offered until the receiver takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one update at a time: no transfer in the cycle after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("update taken while the previous one is in progress");

  // heading flag agrees with the source code, and no source means zero heading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (heading_ok_i == (heading_source_i != SRC_NONE)) &&
                    (heading_ok_i || (heading_out_i == '0)))
    else $error("heading flag, source and value disagree");

  // percentage saturates at full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (speed_pct_i <= PCT_FULL))
    else $error("speed percentage above full scale");

endmodule

bind heading_source_selector_top hss_checker u_hss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .speed_pct_i      (out_o.speed_pct),
  .heading_out_i    (out_o.heading_out),
  .heading_ok_i     (out_o.heading_ok),
  .heading_source_i (out_o.heading_source)
);

`default_nettype wire

// File: verif/hss_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hss_result_check: result checker of the heading source selector
// Watches the update, result and register channels, keeps its own copy of the
// registers, GPS trust flag and last boat fix time, predicts one result per
// accepted update and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module hss_result_check import hss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hss_in_if           nav_i,
  hss_out_if          res_i,
  hss_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int TURN = int'(FULL_TURN);
  localparam int HALF = int'(HALF_TURN);
  localparam int unsigned REPORT_MAX = 10;

  typedef struct {
    logic [SPEED_W-1:0]       speed_pct;
    logic [SPEED_W-1:0]       speed_out;
    logic [HEAD_W-1:0]        course_out;
    logic signed [HEAD_W-1:0] motor_angle;
    logic [HEAD_W-1:0]        heading_out;
    logic                     heading_ok;
    hss_src_e                 heading_source;
    logic                     boat_usable;
  } nav_result_t;

  nav_result_t        expected_results[$];
  logic [SPEED_W-1:0] max_speed;
  logic [SPEED_W-1:0] min_speed;
  logic [SPEED_W-1:0] enter_gps;
  logic [SPEED_W-1:0] leave_gps;
  logic [HOLD_W-1:0]  boat_hold;
  logic               gps_trusted;
  logic [TIME_W-1:0]  boat_seen_ms;
  int unsigned        mismatches = 0;

  assign fail_count_o = mismatches;

  // Advance trust and boat hold state with the update on nav_i, return its result.
  function automatic nav_result_t predict_result();
    nav_result_t        r;
    logic [SPEED_W-1:0] spd;
    logic [TIME_W-1:0]  age;
    logic               usable;
    int unsigned        pct;
    int                 diff;
    spd = nav_i.speed_ok ? nav_i.ground_speed : '0;
    if (!nav_i.speed_ok) begin
      gps_trusted = 1'b0;
    end else if (!gps_trusted && nav_i.ground_speed >= enter_gps) begin
      gps_trusted = 1'b1;
    end else if (gps_trusted && nav_i.ground_speed <= leave_gps) begin
      gps_trusted = 1'b0;
    end
    if (nav_i.boat_ok) begin
      boat_seen_ms = nav_i.now_ms;
    end
    age    = nav_i.now_ms - boat_seen_ms;
    usable = nav_i.boat_ok || (age < {16'd0, boat_hold});

    if (spd == '0 || spd < min_speed) begin
      pct = 0;
    end else if (max_speed == '0) begin
      pct = 32'(PCT_FULL);
    end else begin
      pct = (32'(spd) * 32'(PCT_FULL)) / 32'(max_speed);
      if (pct > 32'(PCT_FULL)) pct = 32'(PCT_FULL);
    end

    diff = int'(32'(nav_i.motor_heading) % 32'(TURN)) -
           int'(32'(nav_i.boat_heading) % 32'(TURN));
    if (diff > HALF) begin
      diff = diff - TURN;
    end else if (diff <= -HALF) begin
      diff = diff + TURN;
    end

    r.speed_pct   = SPEED_W'(pct);
    r.speed_out   = spd;
    r.course_out  = nav_i.course_ok ? nav_i.course_in : '0;
    r.motor_angle = (nav_i.motor_ok && usable) ? HEAD_W'(diff) : '0;
    r.boat_usable = usable;
    if (gps_trusted && nav_i.course_ok) begin
      r.heading_out    = nav_i.course_in;
      r.heading_source = SRC_GPS;
    end else if (usable) begin
      r.heading_out    = nav_i.boat_heading;
      r.heading_source = SRC_BOAT;
    end else if (nav_i.motor_ok) begin
      r.heading_out    = nav_i.motor_heading;
      r.heading_source = SRC_MOTOR;
    end else begin
      r.heading_out    = '0;
      r.heading_source = SRC_NONE;
    end
    r.heading_ok = (r.heading_source != SRC_NONE);
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    nav_result_t want;
    if (!rst_ni) begin
      max_speed    = MAX_SPEED_RST;
      min_speed    = MIN_SPEED_RST;
      enter_gps    = ENTER_GPS_RST;
      leave_gps    = LEAVE_GPS_RST;
      boat_hold    = BOAT_HOLD_RST;
      gps_trusted  = 1'b0;
      boat_seen_ms = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_MAX_SPEED: max_speed = cfg_i.data[SPEED_W-1:0];
          REG_MIN_SPEED: min_speed = cfg_i.data[SPEED_W-1:0];
          REG_ENTER_GPS: enter_gps = cfg_i.data[SPEED_W-1:0];
          REG_LEAVE_GPS: leave_gps = cfg_i.data[SPEED_W-1:0];
          REG_BOAT_HOLD: boat_hold = cfg_i.data[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (nav_i.valid && nav_i.ready) begin
        expected_results.push_back(predict_result());
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: result transfer with nothing expected", $time);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("speed_pct", want.speed_pct, res_i.speed_pct);
          check_field("speed_out", want.speed_out, res_i.speed_out);
          check_field("course_out", want.course_out, res_i.course_out);
          check_field("motor_angle", want.motor_angle, res_i.motor_angle);
          check_field("heading_out", want.heading_out, res_i.heading_out);
          check_field("heading_ok", want.heading_ok, res_i.heading_ok);
          check_field("heading_source", want.heading_source, res_i.heading_source);
          check_field("boat_usable", want.boat_usable, res_i.boat_usable);
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of heading_source_selector_top
// Resets once, sends a directed set of navigation updates at reset settings,
// then random update streams under several register settings, extremes
// included. Both channel sides idle at random; the checker predicts and
// compares, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb import hss_pkg::*;;

  localparam logic [IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 262;
  localparam int unsigned MAX_GAP      = 17;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int          SPEED_TOP    = 10000;
  localparam int          HEAD_TOP     = 35999;

  typedef struct {
    logic               speed_ok;
    logic [SPEED_W-1:0] ground_speed;
    logic               course_ok;
    logic [HEAD_W-1:0]  course_in;
    logic               motor_ok;
    logic [HEAD_W-1:0]  motor_heading;
    logic               boat_ok;
    logic [HEAD_W-1:0]  boat_heading;
    logic [TIME_W-1:0]  now_ms;
  } nav_upd_t;

  logic        clk;
  logic        rst_n;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // current register values, used to aim random speeds and times
  int max_cfg   = int'(MAX_SPEED_RST);
  int min_cfg   = int'(MIN_SPEED_RST);
  int enter_cfg = int'(ENTER_GPS_RST);
  int leave_cfg = int'(LEAVE_GPS_RST);
  int hold_cfg  = int'(BOAT_HOLD_RST);

  logic [TIME_W-1:0] clock_ms = '0;
  logic [TIME_W-1:0] boat_ms  = '0;
  logic [HEAD_W-1:0] boat_hdg = '0;

  hss_in_if  nav_if ();
  hss_out_if res_if ();
  hss_cfg_if cfg_if ();

  heading_source_selector_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (nav_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  hss_result_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .nav_i        (nav_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin : watchdog
    #10_000_000;
    $display("heading_source_selector_top verification failed");
    $finish;
  end

  // Drop valid and hold until every expected result has been taken.
  task automatic wait_drained();
    nav_if.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_update(input nav_upd_t u);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      nav_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nav_if.speed_ok      <= u.speed_ok;
    nav_if.ground_speed  <= u.ground_speed;
    nav_if.course_ok     <= u.course_ok;
    nav_if.course_in     <= u.course_in;
    nav_if.motor_ok      <= u.motor_ok;
    nav_if.motor_heading <= u.motor_heading;
    nav_if.boat_ok       <= u.boat_ok;
    nav_if.boat_heading  <= u.boat_heading;
    nav_if.now_ms        <= u.now_ms;
    nav_if.valid         <= 1'b1;
    do @(posedge clk); while (!nav_if.ready);
  endtask

  task automatic send_nav(input logic so, input logic [SPEED_W-1:0] gs,
                          input logic co, input logic [HEAD_W-1:0] crs,
                          input logic mo, input logic [HEAD_W-1:0] mh,
                          input logic bo, input logic [HEAD_W-1:0] bh,
                          input logic [TIME_W-1:0] now);
    nav_upd_t u;
    u.speed_ok      = so;
    u.ground_speed  = gs;
    u.course_ok     = co;
    u.course_in     = crs;
    u.motor_ok      = mo;
    u.motor_heading = mh;
    u.boat_ok       = bo;
    u.boat_heading  = bh;
    u.now_ms        = now;
    send_update(u);
  endtask

  function automatic logic [SPEED_W-1:0] speed_near(int center);
    int v;
    v = center + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > SPEED_TOP) v = SPEED_TOP;
    return SPEED_W'(v);
  endfunction

  // Mostly plausible updates along a running time line, some pure noise.
  function automatic nav_upd_t rand_update();
    nav_upd_t u;
    if ($urandom_range(0, 9) == 0) begin
      u.speed_ok      = 1'($urandom_range(0, 1));
      u.ground_speed  = SPEED_W'($urandom_range(0, (1 << SPEED_W) - 1));
      u.course_ok     = 1'($urandom_range(0, 1));
      u.course_in     = HEAD_W'($urandom_range(0, (1 << HEAD_W) - 1));
      u.motor_ok      = 1'($urandom_range(0, 1));
      u.motor_heading = HEAD_W'($urandom_range(0, (1 << HEAD_W) - 1));
      u.boat_ok       = 1'($urandom_range(0, 1));
      u.boat_heading  = HEAD_W'($urandom_range(0, (1 << HEAD_W) - 1));
      u.now_ms        = $urandom();
      return u;
    end
    u.speed_ok = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 4))
      0:       u.ground_speed = speed_near(enter_cfg);
      1:       u.ground_speed = speed_near(leave_cfg);
      2:       u.ground_speed = speed_near(min_cfg);
      3:       u.ground_speed = speed_near(max_cfg);
      default: u.ground_speed = SPEED_W'($urandom_range(0, SPEED_TOP));
    endcase
    u.boat_ok = ($urandom_range(0, 9) < 6);
    case ($urandom_range(0, 7))
      // land on both edges of the hold window
      0:       clock_ms = u.boat_ok ? clock_ms : boat_ms + hold_cfg - 1;
      1:       clock_ms = u.boat_ok ? clock_ms : boat_ms + hold_cfg;
      2:       clock_ms = clock_ms + $urandom_range(0, 2 * hold_cfg + 2);
      default: clock_ms = clock_ms + $urandom_range(0, 300);
    endcase
    if (u.boat_ok) boat_ms = clock_ms;
    boat_hdg = HEAD_W'((32'(boat_hdg) + $urandom_range(0, 2000)) % (HEAD_TOP + 1));
    u.boat_heading = boat_hdg;
    case ($urandom_range(0, 5))
      0:       u.motor_heading = HEAD_W'((32'(boat_hdg) + 18000) % (HEAD_TOP + 1));
      1:       u.motor_heading = boat_hdg;
      default: u.motor_heading = HEAD_W'($urandom_range(0, HEAD_TOP));
    endcase
    u.motor_ok  = ($urandom_range(0, 4) != 0);
    u.course_ok = ($urandom_range(0, 4) != 0);
    u.course_in = HEAD_W'($urandom_range(0, HEAD_TOP));
    u.now_ms    = clock_ms;
    return u;
  endfunction

  task automatic set_phase(input int unsigned ph);
    logic [DATA_W-1:0] hi;
    hi = '0;
    case (ph)
      0: begin
        max_cfg = SPEED_TOP; min_cfg = 0; enter_cfg = 0; leave_cfg = 0; hold_cfg = 0;
      end
      1: begin
        max_cfg = 1; min_cfg = SPEED_TOP; enter_cfg = SPEED_TOP; leave_cfg = SPEED_TOP;
        hold_cfg = 65535;
      end
      2: begin
        // zero maximum speed, crossed thresholds
        max_cfg = 0; min_cfg = 1; enter_cfg = 20; leave_cfg = 100; hold_cfg = 1;
        write_reg(REG_SPARE, DATA_W'($urandom_range(0, (1 << DATA_W) - 1)));
      end
      default: begin
        max_cfg   = $urandom_range(1, SPEED_TOP);
        min_cfg   = $urandom_range(0, max_cfg / 2);
        leave_cfg = $urandom_range(0, 2000);
        enter_cfg = leave_cfg + $urandom_range(0, 2000);
        hold_cfg  = $urandom_range(0, 5000);
        if (ph == 5) hi = 16'hC000;
        if (ph == PHASES - 1) begin
          // run the time line across the wrap
          clock_ms = 32'hFFFF_0000;
          boat_ms  = clock_ms;
        end
      end
    endcase
    write_reg(REG_MAX_SPEED, hi | DATA_W'(max_cfg));
    write_reg(REG_MIN_SPEED, hi | DATA_W'(min_cfg));
    write_reg(REG_ENTER_GPS, hi | DATA_W'(enter_cfg));
    write_reg(REG_LEAVE_GPS, hi | DATA_W'(leave_cfg));
    write_reg(REG_BOAT_HOLD, DATA_W'(hold_cfg));
  endtask

  initial begin : receiver
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_calm = ~rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    rst_n                <= 1'b0;
    nav_if.valid         <= 1'b0;
    nav_if.speed_ok      <= 1'b0;
    nav_if.ground_speed  <= '0;
    nav_if.course_ok     <= 1'b0;
    nav_if.course_in     <= '0;
    nav_if.motor_ok      <= 1'b0;
    nav_if.motor_heading <= '0;
    nav_if.boat_ok       <= 1'b0;
    nav_if.boat_heading  <= '0;
    nav_if.now_ms        <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_MAX_SPEED;
    cfg_if.data          <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // boat usable right after reset, then nothing usable
    send_nav(0, 0, 0, 0, 0, 0, 0, 1234, 10);
    send_nav(0, 0, 0, 0, 0, 0, 0, 0, 5000);
    send_nav(1, 0, 1, 0, 1, 0, 0, 0, 5100);
    // trust sets at enter speed, holds between thresholds, clears at leave
    send_nav(1, 60, 1, 35999, 1, 100, 0, 0, 5200);
    send_nav(1, 50, 0, 9000, 1, 0, 1, 18000, 5300);
    send_nav(1, 41, 1, 100, 1, 18000, 0, 0, 5400);
    send_nav(1, 40, 1, 100, 1, 35999, 0, 0, 5500);
    // dead band edge and last millisecond of the hold window, then motor fallback
    send_nav(1, 29, 1, 200, 1, 300, 0, 400, 6299);
    send_nav(1, 30, 1, 200, 1, 300, 0, 400, 6300);
    send_nav(1, 10000, 1, 12345, 1, 300, 0, 400, 6400);
    send_nav(0, 10000, 1, 12345, 1, 300, 0, 400, 6500);
    // headings beyond a full turn
    send_nav(1, 199, 1, 65535, 1, 65535, 1, 36000, 6600);
    send_nav(1, 16383, 0, 0, 1, 36000, 1, 65535, 6700);
    // hold window across the time wrap
    send_nav(1, 100, 0, 0, 1, 500, 1, 700, 32'hFFFF_FF00);
    send_nav(1, 100, 0, 0, 1, 500, 0, 700, 32'h0000_0010);
    send_nav(1, 16383, 1, 16'hFFFF, 1, 16'hFFFF, 1, 16'hFFFF, 32'hFFFF_FFFF);
    send_nav(1, 0, 0, 0, 0, 0, 0, 0, 0);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      set_phase(ph);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 63) == 0) tx_calm = ~tx_calm;
        if ($urandom_range(0, 149) == 0) wait_drained();
        send_update(rand_update());
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("heading_source_selector_top verification clean");
    end else begin
      $display("heading_source_selector_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/hss_pkg.sv
hdl/hss_if.sv
hdl/hss_div.sv
hdl/hss_sel.sv
hdl/heading_source_selector_top.sv
hdl/hss_checker.sv
verif/hss_result_check.sv
verif/tb.sv
